// File: hdl/token_bucket_rate_limiter_macros.svh
// Assertion helpers used by the token bucket RTL.
`ifndef TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define TBRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define TBRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tbrl_pkg.sv
package tbrl_pkg;

  // Fixed field widths
  localparam int unsigned NOW_W         = 48;
  localparam int unsigned LEVEL_WHOLE_W = 17;
  localparam int unsigned INTERVAL_W    = 24;
  localparam int unsigned BURST_W       = 16;
  localparam int unsigned ELAPSED_W     = 32;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned CFG_IDX_W     = 1;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd1000;
  localparam logic [BURST_W-1:0]    BURST_RESET    = 16'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TOKENS    = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_REFILL  = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

endpackage

// File: hdl/token_bucket_rate_limiter.sv
// Channel  | Direction | Handshake              | Beat contents
// ---------+-----------+------------------------+---------------------------------
// in       | input     | in_valid_i / in_stall_o | command_i, now_us_i
// out      | output    | out_valid_o/out_stall_i | granted_o, notify_o, level_whole_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Sequence: start, consume, no-op and a refill that adds nothing go from the
//   input beat to ST_DONE and then into the output register. A refill that adds
//   tokens passes through ST_DIV, where the restoring divider retires one
//   quotient bit per cycle, then through ST_ADD and ST_DONE.
// One item at a time: in_stall_o is high from accept until the result moves
//   into the output register.
// Reset: async, active low; bucket empty, stamp zero, notify armed. No
//   clearing pass. cfg_ready_o is always high.
`include "token_bucket_rate_limiter_macros.svh"

module token_bucket_rate_limiter #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned TIME_BITS     = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input beats
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [tbrl_pkg::CMD_W-1:0]           command_i,
  input  logic [tbrl_pkg::NOW_W-1:0]           now_us_i,
  // result beats
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 granted_o,
  output logic                                 notify_o,
  output logic [tbrl_pkg::LEVEL_WHOLE_W-1:0]   level_whole_o,
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tbrl_pkg::INTERVAL_W-1:0]      cfg_data_i
);

  // Level: Q17.FRACTION_BITS. Quotient: elapsed (32 bits) scaled by 2^FB, over the interval.
  localparam int unsigned LW    = tbrl_pkg::LEVEL_WHOLE_W + FRACTION_BITS;
  localparam int unsigned QW    = tbrl_pkg::ELAPSED_W + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam int unsigned DW    = tbrl_pkg::INTERVAL_W;

  localparam logic [LW-1:0]        ONE_TOKEN = LW'(1) << FRACTION_BITS;
  localparam logic [TIME_BITS-1:0] ELAPSED_LIMIT =
    TIME_BITS'({tbrl_pkg::ELAPSED_W{1'b1}});

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [LW-1:0]                    level_q, level_d;
  logic [TIME_BITS-1:0]             stamp_q, stamp_d;
  logic                             armed_q, armed_d;
  logic [DW-1:0]                    interval_q;
  logic [tbrl_pkg::BURST_W-1:0]     burst_q;
  logic [DW-1:0]                    div_q, div_d;
  logic [DW-1:0]                    rem_q, rem_d;
  logic [QW-1:0]                    dq_q, dq_d;   // dividend in, quotient out
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic                             res_granted_q, res_granted_d;
  logic                             res_notify_q, res_notify_d;
  logic                             out_valid_q, out_valid_d;
  logic                             granted_q, granted_d;
  logic                             notify_q, notify_d;
  logic [tbrl_pkg::LEVEL_WHOLE_W-1:0] lvl_out_q, lvl_out_d;

  logic                             in_beat;
  tbrl_pkg::cmd_e                   cmd;
  logic [tbrl_pkg::NOW_W+TIME_BITS-1:0] now_wide;
  logic [TIME_BITS-1:0]             now_t;
  logic [TIME_BITS-1:0]             elapsed_full;
  logic [tbrl_pkg::ELAPSED_W-1:0]   elapsed;
  logic [LW-1:0]                    depth;
  logic                             advance;
  logic                             below;
  logic [DW:0]                      rem_shift;
  logic                             step_ge;
  logic [DW:0]                      rem_sub;
  logic [QW:0]                      sum;
  logic [QW:0]                      depth_ext;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_beat     = in_valid_i && !in_stall_o;
  assign cmd         = tbrl_pkg::cmd_e'(command_i);

  // Time is taken modulo 2^TIME_BITS
  assign now_wide = {{TIME_BITS{1'b0}}, now_us_i};
  assign now_t    = now_wide[TIME_BITS-1:0];

  assign depth   = {({1'b0, burst_q} + tbrl_pkg::LEVEL_WHOLE_W'(1)), {FRACTION_BITS{1'b0}}};
  assign advance = (now_t > stamp_q);
  assign below   = (level_q < depth);

  // Long gaps clamp to 2^32-1
  assign elapsed_full = now_t - stamp_q;
  assign elapsed = (elapsed_full > ELAPSED_LIMIT) ? '1
                                                  : elapsed_full[tbrl_pkg::ELAPSED_W-1:0];

  // Restoring divider step
  assign rem_shift = {rem_q, dq_q[QW-1]};
  assign step_ge   = (rem_shift >= {1'b0, div_q});
  assign rem_sub   = rem_shift - {1'b0, div_q};

  // Add and saturate at depth
  assign sum       = {{(QW+1-LW){1'b0}}, level_q} + {1'b0, dq_q};
  assign depth_ext = {{(QW+1-LW){1'b0}}, depth};

  always_comb begin
    state_d       = state_q;
    level_d       = level_q;
    stamp_d       = stamp_q;
    armed_d       = armed_q;
    div_d         = div_q;
    rem_d         = rem_q;
    dq_d          = dq_q;
    cnt_d         = cnt_q;
    res_granted_d = res_granted_q;
    res_notify_d  = res_notify_q;
    out_valid_d   = out_valid_q && out_stall_i;
    granted_d     = granted_q;
    notify_d      = notify_q;
    lvl_out_d     = lvl_out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          res_granted_d = 1'b0;
          res_notify_d  = 1'b0;
          state_d       = ST_DONE;
          case (cmd)
            tbrl_pkg::CMD_START: begin
              // fill to depth; the follow-up refill at the same time adds nothing
              level_d      = depth;
              stamp_d      = now_t;
              res_notify_d = armed_q;
              armed_d      = 1'b0;
            end
            tbrl_pkg::CMD_REFILL: begin
              stamp_d      = now_t;
              res_notify_d = armed_q;
              armed_d      = 1'b0;
              if (advance && below) begin
                div_d   = (interval_q == '0) ? DW'(1) : interval_q;
                rem_d   = '0;
                dq_d    = {elapsed, {FRACTION_BITS{1'b0}}};
                cnt_d   = CNT_W'(QW - 1);
                state_d = ST_DIV;
              end
            end
            tbrl_pkg::CMD_CONSUME: begin
              if (level_q >= ONE_TOKEN) begin
                level_d       = level_q - ONE_TOKEN;
                res_granted_d = 1'b1;
              end else begin
                armed_d = 1'b1;
              end
            end
            default: ;  // no-op leaves state alone
          endcase
        end
      end
      ST_DIV: begin
        rem_d = step_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
        dq_d  = {dq_q[QW-2:0], step_ge};
        if (cnt_q == '0) begin
          state_d = ST_ADD;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_ADD: begin
        level_d = (sum > depth_ext) ? depth : sum[LW-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          granted_d   = res_granted_q;
          notify_d    = res_notify_q;
          lvl_out_d   = level_q[LW-1:FRACTION_BITS];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= '0;
      stamp_q     <= '0;
      armed_q     <= 1'b1;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      stamp_q     <= stamp_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    div_q         <= div_d;
    rem_q         <= rem_d;
    dq_q          <= dq_d;
    res_granted_q <= res_granted_d;
    res_notify_q  <= res_notify_d;
    granted_q     <= granted_d;
    notify_q      <= notify_d;
    lvl_out_q     <= lvl_out_d;
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= tbrl_pkg::INTERVAL_RESET;
      burst_q    <= tbrl_pkg::BURST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tbrl_pkg::REG_REFILL_INTERVAL: interval_q <= cfg_data_i;
        tbrl_pkg::REG_BURST_TOKENS:    burst_q    <= cfg_data_i[tbrl_pkg::BURST_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign granted_o     = granted_q;
  assign notify_o      = notify_q;
  assign level_whole_o = lvl_out_q;

  // Checks
  `TBRL_ASSERT_NEXT(a_beat_leaves_idle, clk_i, rst_ni, in_beat, state_q != ST_IDLE,
    "accepted beat did not start the sequencer")
  `TBRL_ASSERT_NOW(a_rem_below_div, clk_i, rst_ni, state_q == ST_DIV,
    (div_q != '0) && (rem_q < div_q), "divider remainder out of range")
  `TBRL_ASSERT_NOW(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q),
    $past(state_q) == ST_DONE, "result appeared without a finished item")
  `TBRL_ASSERT_NOW(a_grant_xor_notify, clk_i, rst_ni, out_valid_q,
    !(granted_q && notify_q), "grant and notify raised together")

endmodule
